@@ sv/bmg_pkg.sv @@
// bmg_pkg: shared types, widths, stage counts and constants for the gaussian generator
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package bmg_pkg;

   typedef struct packed {
      logic [31:0] radius_word;
      logic [31:0] angle_word;
   } req_type;

   typedef struct packed {
      logic signed [23:0] cosine_sample;
      logic signed [23:0] sine_sample;
   } rsp_type;

   localparam logic [7:0] CSR_MEAN = 8'd0;
   localparam logic [7:0] CSR_DEV  = 8'd1;

   localparam int LOG_W      = 21;
   localparam int SQ_W       = 38;
   localparam int ROOT_W     = 20;
   localparam int TRIG_W     = 33;
   localparam int FRAC_STEPS = 16;
   localparam int SQRT_STEPS = 19;

   localparam int LOG2_LAT  = FRAC_STEPS + 2;
   localparam int SQRT_LAT  = SQRT_STEPS + 1;
   localparam int TRIG_LAT  = 6;
   localparam int SCALE_LAT = 3;
   localparam int ANG_DLY   = LOG2_LAT + SQRT_LAT - TRIG_LAT;
   localparam int TOTAL_LAT = LOG2_LAT + SQRT_LAT + 1 + SCALE_LAT;

   localparam logic [16:0] TWO_LN2_Q16 = 17'd90852;
   localparam logic [16:0] T_ONE       = 17'h10000;

   localparam logic signed [TRIG_W-1:0] SIN_COEF [5] = '{
      33'sd1686629713, -33'sd693598669, 33'sd85569306, -33'sd5026995, 33'sd172272
   };

   localparam logic signed [23:0] SAT_HI = 24'sh7FFFFF;
   localparam logic signed [23:0] SAT_LO = -24'sh800000;

   // fraction of log2 for a normalized mantissa, elaboration only
   function automatic logic [LOG_W-1:0] log2_norm(input logic [31:0] m0);
      logic [63:0] m;
      logic [15:0] frac;
      m = 64'(m0);
      frac = '0;
      for (int i = 0; i < FRAC_STEPS; i++) begin
         m = (m * m) >> 31;
         frac = {frac[14:0], 1'b0};
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return {5'd31, frac};
   endfunction

   localparam logic [LOG_W-1:0] LOG2_MAX = log2_norm(32'hFFFFFFFF);

endpackage
`default_nettype wire

@@ sv/bmg_log2.sv @@
// bmg_log2: pipelined Q.16 log2 of a 32-bit word, one squaring per stage
// depends on bmg_pkg
`timescale 1ns / 1ps
`default_nettype none
module bmg_log2 import bmg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [31:0]      in_word,
   output logic             out_valid,
   output logic [LOG_W-1:0] out_log
);

   logic [4:0]          enc_in;
   logic [31:0]         word_ff;
   logic [4:0]          exp_ff  [0:LOG2_LAT-1];
   logic [31:0]         mant_ff [0:FRAC_STEPS];
   logic [15:0]         frac_ff [0:FRAC_STEPS];
   logic [LOG2_LAT-1:0] vld_ff;

   always_comb begin
      enc_in = '0;
      for (int i = 0; i < 32; i++) begin
         if (in_word[i]) enc_in = 5'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LOG2_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      word_ff    <= in_word;
      exp_ff[0]  <= enc_in;
      mant_ff[0] <= 32'(word_ff << (5'd31 - exp_ff[0]));
      frac_ff[0] <= '0;
      exp_ff[1]  <= exp_ff[0];
   end

   for (genvar k = 0; k < FRAC_STEPS; k++) begin : g_sq
      logic [63:0] prod;
      logic [32:0] half;
      logic [31:0] mant_in;
      assign prod    = 64'(mant_ff[k]) * 64'(mant_ff[k]);
      assign half    = prod[63:31];
      assign mant_in = half[32] ? half[32:1] : half[31:0];
      always_ff @(posedge clock) begin
         mant_ff[k+1] <= mant_in;
         frac_ff[k+1] <= {frac_ff[k][14:0], half[32]};
         exp_ff[k+2]  <= exp_ff[k+1];
      end
   end

   assign out_valid = vld_ff[LOG2_LAT-1];
   assign out_log   = {exp_ff[LOG2_LAT-1], frac_ff[FRAC_STEPS]};

endmodule
`default_nettype wire

@@ sv/bmg_sqrt.sv @@
// bmg_sqrt: radius r = floor(sqrt(-2 ln u)) from the log2 value, one root bit per stage
// depends on bmg_pkg
`timescale 1ns / 1ps
`default_nettype none
module bmg_sqrt import bmg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [LOG_W-1:0]  in_log,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root
);

   logic [LOG_W-1:0]    dist_in;
   logic [SQ_W-1:0]     rad_ff [0:SQRT_STEPS];
   logic [SQ_W-1:0]     res_ff [0:SQRT_STEPS];
   logic [SQRT_LAT-1:0] vld_ff;

   assign dist_in = (in_log < LOG2_MAX) ? LOG2_MAX - in_log : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[SQRT_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      rad_ff[0] <= SQ_W'(dist_in) * SQ_W'(TWO_LN2_Q16);
      res_ff[0] <= '0;
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_bit
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [SQ_W-1:0] trial;
      logic            take;
      assign trial = res_ff[k] + BIT;
      assign take  = rad_ff[k] >= trial;
      always_ff @(posedge clock) begin
         rad_ff[k+1] <= take ? rad_ff[k] - trial : rad_ff[k];
         res_ff[k+1] <= take ? (res_ff[k] >> 1) + BIT : res_ff[k] >> 1;
      end
   end

   assign out_valid = vld_ff[SQRT_LAT-1];
   assign out_root  = res_ff[SQRT_STEPS][ROOT_W-1:0];

endmodule
`default_nettype wire

@@ sv/bmg_trig.sv @@
// bmg_trig: quarter-wave sine in Q30, degree-9 odd polynomial, one horner step per stage
// depends on bmg_pkg
`timescale 1ns / 1ps
`default_nettype none
module bmg_trig import bmg_pkg::*; (
   input  logic                     clock,
   input  logic [16:0]              in_t,
   output logic signed [TRIG_W-1:0] out_val
);

   logic [61:0]              tsq;
   logic [30:0]              tq_ff [0:4];
   logic [30:0]              t2_ff [0:3];
   logic signed [TRIG_W-1:0] p_ff  [1:4];
   logic signed [63:0]       fin_prod;
   logic signed [TRIG_W-1:0] out_ff;

   assign tsq = 62'({in_t, 14'b0}) * 62'({in_t, 14'b0});

   always_ff @(posedge clock) begin
      tq_ff[0] <= {in_t, 14'b0};
      t2_ff[0] <= tsq[60:30];
   end

   for (genvar j = 0; j < 4; j++) begin : g_horner
      logic signed [TRIG_W-1:0] p_prev;
      logic signed [63:0]       prod;
      if (j == 0) begin : g_first
         assign p_prev = SIN_COEF[4];
      end else begin : g_next
         assign p_prev = p_ff[j];
      end
      assign prod = 64'(p_prev) * 64'(signed'({1'b0, t2_ff[j]}));
      always_ff @(posedge clock) begin
         p_ff[j+1]  <= SIN_COEF[3-j] + TRIG_W'(prod >>> 30);
         tq_ff[j+1] <= tq_ff[j];
      end
      if (j < 3) begin : g_t2
         always_ff @(posedge clock) begin
            t2_ff[j+1] <= t2_ff[j];
         end
      end
   end

   assign fin_prod = 64'(p_ff[4]) * 64'(signed'({1'b0, tq_ff[4]}));

   always_ff @(posedge clock) begin
      out_ff <= TRIG_W'(fin_prod >>> 30);
   end

   assign out_val = out_ff;

endmodule
`default_nettype wire

@@ sv/bmg_scale.sv @@
// bmg_scale: r times cos/sin, deviation scaling with rounding, mean offset and saturation
// depends on bmg_pkg
`timescale 1ns / 1ps
`default_nettype none
module bmg_scale import bmg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [ROOT_W-1:0]        in_root,
   input  logic signed [TRIG_W-1:0] in_cos,
   input  logic signed [TRIG_W-1:0] in_sin,
   input  logic signed [15:0]       mean,
   input  logic [15:0]              dev,
   output logic                     out_valid,
   output rsp_type                  out_data
);

   logic signed [63:0]    xc_prod, xs_prod, yc_prod, ys_prod;
   logic signed [21:0]    xc_ff, xs_ff;
   logic signed [22:0]    yc_ff, ys_ff;
   logic signed [24:0]    sc_in, ss_in;
   rsp_type               data_ff;
   logic [SCALE_LAT-1:0]  vld_ff;

   function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
      if (v > 25'(SAT_HI)) return SAT_HI;
      if (v < 25'(SAT_LO)) return SAT_LO;
      return v[23:0];
   endfunction

   assign xc_prod = 64'(signed'({1'b0, in_root})) * 64'(in_cos);
   assign xs_prod = 64'(signed'({1'b0, in_root})) * 64'(in_sin);
   assign yc_prod = 64'(xc_ff) * 64'(signed'({1'b0, dev})) + 64'sd32768;
   assign ys_prod = 64'(xs_ff) * 64'(signed'({1'b0, dev})) + 64'sd32768;
   assign sc_in   = 25'(yc_ff) + 25'(mean);
   assign ss_in   = 25'(ys_ff) + 25'(mean);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[SCALE_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      xc_ff <= 22'(xc_prod >>> 30);
      xs_ff <= 22'(xs_prod >>> 30);
      yc_ff <= 23'(yc_prod >>> 16);
      ys_ff <= 23'(ys_prod >>> 16);
      data_ff.cosine_sample <= sat24(sc_in);
      data_ff.sine_sample   <= sat24(ss_in);
   end

   assign out_valid = vld_ff[SCALE_LAT-1];
   assign out_data  = data_ff;

endmodule
`default_nettype wire

@@ sv/box_muller_gaussian_generator_core.sv @@
// box_muller_gaussian_generator_core: top level of the box-muller gaussian generator
// depends on bmg_pkg, bmg_log2, bmg_sqrt, bmg_trig, bmg_scale
//
//   channel  ports                          direction  beat
//   request  start, busy, req_data          in         start && !busy
//   response rsp_valid, rsp_data            out        rsp_valid, one cycle
//   csr      csr_valid, csr_ready, csr_*    in         csr_valid && csr_ready
//
// one request per cycle; log2 has 16 squaring stages, the square root 19 bit stages.
// a request with a zero word gives no result. busy stays low.
// synchronous reset clears valid bits and the mean, sets dev to 256, no clearing pass.
// the receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none
module box_muller_gaussian_generator_core import bmg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic                     in_vld;
   logic signed [15:0]       mean_ff;
   logic [15:0]              dev_ff;
   logic                     log_vld;
   logic [LOG_W-1:0]         log_val;
   logic                     root_vld;
   logic [ROOT_W-1:0]        root_val;
   logic [17:0]              ang_ff  [0:ANG_DLY-1];
   logic [1:0]               quad_ff [0:TRIG_LAT-1];
   logic [16:0]              t_sin, t_cos;
   logic signed [TRIG_W-1:0] sin_val, cos_val;
   logic signed [TRIG_W-1:0] cv_in, sv_in, cv_ff, sv_ff;
   logic [ROOT_W-1:0]        root_ff;
   logic                     sel_vld_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign in_vld    = start && !busy && (req_data.radius_word != '0)
                      && (req_data.angle_word != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff <= '0;
         dev_ff  <= 16'd256;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MEAN: mean_ff <= csr_data;
            CSR_DEV:  dev_ff  <= csr_data;
            default:  ;
         endcase
      end
   end

   bmg_log2 u_log2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_vld),
      .in_word   (req_data.radius_word),
      .out_valid (log_vld),
      .out_log   (log_val)
   );

   bmg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (log_vld),
      .in_log    (log_val),
      .out_valid (root_vld),
      .out_root  (root_val)
   );

   // angle waits so the trig result lines up with the radius
   always_ff @(posedge clock) begin
      ang_ff[0] <= req_data.angle_word[31:14];
      for (int i = 1; i < ANG_DLY; i++) ang_ff[i] <= ang_ff[i-1];
      quad_ff[0] <= ang_ff[ANG_DLY-1][17:16];
      for (int i = 1; i < TRIG_LAT; i++) quad_ff[i] <= quad_ff[i-1];
   end

   assign t_sin = {1'b0, ang_ff[ANG_DLY-1][15:0]};
   assign t_cos = T_ONE - t_sin;

   bmg_trig u_sin (
      .clock   (clock),
      .in_t    (t_sin),
      .out_val (sin_val)
   );

   bmg_trig u_cos (
      .clock   (clock),
      .in_t    (t_cos),
      .out_val (cos_val)
   );

   always_comb begin
      case (quad_ff[TRIG_LAT-1])
         2'd0: begin
            cv_in = cos_val;
            sv_in = sin_val;
         end
         2'd1: begin
            cv_in = -sin_val;
            sv_in = cos_val;
         end
         2'd2: begin
            cv_in = -cos_val;
            sv_in = -sin_val;
         end
         default: begin
            cv_in = sin_val;
            sv_in = -cos_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_vld_ff <= 1'b0;
      end else begin
         sel_vld_ff <= root_vld;
      end
   end

   always_ff @(posedge clock) begin
      root_ff <= root_val;
      cv_ff   <= cv_in;
      sv_ff   <= sv_in;
   end

   bmg_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_vld_ff),
      .in_root   (root_ff),
      .in_cos    (cv_ff),
      .in_sin    (sv_ff),
      .mean      (mean_ff),
      .dev       (dev_ff),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      in_vld |-> ##TOTAL_LAT rsp_valid)
      else $error("result missing after accepted beat");

   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(in_vld, TOTAL_LAT))
      else $error("result without a matching beat");

   a_zero_drop: assert property (@(posedge clock) disable iff (reset)
      (start && (req_data.radius_word == '0)) |-> ##TOTAL_LAT !rsp_valid)
      else $error("zero radius word produced a result");

endmodule
`default_nettype wire
